### hw/rtl/fpa_pkg.sv
// Shared types, codes and helpers for the fixed-partition allocator.
`timescale 1ns / 1ps

package fpa_pkg;

   // Partition count and derived widths
   localparam int NUM_PARTS = 16;
   localparam int IDX_W     = (NUM_PARTS > 1) ? $clog2(NUM_PARTS) : 1;
   localparam int CNT_W     = $clog2(NUM_PARTS + 1);

   // Field widths fixed by the interface
   localparam int MODE_W     = 2;
   localparam int PIDX_W     = 4;
   localparam int AMOUNT_W   = 16;
   localparam int PID_W      = 8;
   localparam int STATUS_W   = 3;
   localparam int GRANT_W    = 4;
   localparam int FREED_W    = 5;
   localparam int POLICY_W   = 2;
   localparam int LIMIT_W    = 5;
   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = 5;

   // Item modes
   localparam logic [MODE_W-1:0] MODE_LOAD    = 2'd0;
   localparam logic [MODE_W-1:0] MODE_ALLOC   = 2'd1;
   localparam logic [MODE_W-1:0] MODE_RELEASE = 2'd2;

   // Result status codes
   localparam logic [STATUS_W-1:0] STATUS_GRANTED  = 3'd0;
   localparam logic [STATUS_W-1:0] STATUS_NOFIT    = 3'd1;
   localparam logic [STATUS_W-1:0] STATUS_RELEASED = 3'd2;
   localparam logic [STATUS_W-1:0] STATUS_NONE     = 3'd3;
   localparam logic [STATUS_W-1:0] STATUS_LOADED   = 3'd4;

   // Fit policies; any other code acts as first fit
   localparam logic [POLICY_W-1:0] POLICY_FIRST = 2'd0;
   localparam logic [POLICY_W-1:0] POLICY_BEST  = 2'd1;
   localparam logic [POLICY_W-1:0] POLICY_WORST = 2'd2;

   // Register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_FIT_POLICY = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_PARTS_USED = 1'd1;

   localparam logic [LIMIT_W-1:0] LIMIT_RESET = 5'd16;

   typedef struct packed {
      logic [MODE_W-1:0]   mode;
      logic [PIDX_W-1:0]   partition_index;
      logic [AMOUNT_W-1:0] amount;
      logic [PID_W-1:0]    process_id;
   } req_type;

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [GRANT_W-1:0]  granted_partition;
      logic [FREED_W-1:0]  freed_count;
   } rsp_type;

   // Search token that walks the chain one cell per cycle
   typedef struct packed {
      logic                valid;
      logic                is_release;
      logic [AMOUNT_W-1:0] amount;
      logic [PID_W-1:0]    pid;
      logic                found;
      logic [IDX_W-1:0]    pick;
      logic [AMOUNT_W-1:0] pick_size;
      logic [CNT_W-1:0]    freed;
   } probe_type;

   // Settings seen by every cell
   typedef struct packed {
      logic [POLICY_W-1:0] policy;
      logic [LIMIT_W-1:0]  limit;
   } cfg_type;

   // Size write broadcast
   typedef struct packed {
      logic                valid;
      logic [PIDX_W-1:0]   index;
      logic [AMOUNT_W-1:0] size;
   } load_type;

   // Ownership commit broadcast
   typedef struct packed {
      logic             valid;
      logic [IDX_W-1:0] index;
      logic [PID_W-1:0] owner;
   } grant_type;

   typedef enum logic [1:0] {
      FPA_IDLE,
      FPA_SCAN,
      FPA_FINISH
   } state_type;

   // Low four bits of a partition index, zero-extended when narrower
   function automatic logic [GRANT_W-1:0] idx_low4(logic [IDX_W-1:0] idx);
      logic [IDX_W+GRANT_W-1:0] wide;
      wide = {{GRANT_W{1'b0}}, idx};
      return wide[GRANT_W-1:0];
   endfunction

endpackage

### hw/rtl/fpa_cell.sv
// One partition cell: holds size, busy and owner, and updates the passing search token.
`timescale 1ns / 1ps

module fpa_cell (
   input  logic                     clock,
   input  logic                     reset,
   input  logic [fpa_pkg::IDX_W-1:0] cell_index,
   input  fpa_pkg::cfg_type         cfg,
   input  fpa_pkg::load_type        load,
   input  fpa_pkg::grant_type       grant,
   input  fpa_pkg::probe_type       probe_prev,
   output fpa_pkg::probe_type       probe_next
);

   logic [fpa_pkg::AMOUNT_W-1:0] size_ff;
   logic                         busy_ff;
   logic                         busy_in;
   logic [fpa_pkg::PID_W-1:0]    owner_ff;
   fpa_pkg::probe_type           probe_ff;
   fpa_pkg::probe_type           probe_in;
   logic                         probe_valid_ff;

   logic in_range;
   logic fits;
   logic take;
   logic frees;

   // Decide what this cell does to the token
   always_comb begin
      in_range = 32'(cell_index) < 32'(cfg.limit);
      fits     = probe_prev.valid && !probe_prev.is_release && in_range && !busy_ff
                 && (size_ff >= probe_prev.amount);
      take     = 1'b0;
      if (fits) begin
         if (!probe_prev.found) begin
            take = 1'b1;
         end else if (cfg.policy == fpa_pkg::POLICY_BEST) begin
            take = size_ff < probe_prev.pick_size;
         end else if (cfg.policy == fpa_pkg::POLICY_WORST) begin
            take = size_ff > probe_prev.pick_size;
         end
      end
      frees = probe_prev.valid && probe_prev.is_release && in_range && busy_ff
              && (owner_ff == probe_prev.pid);

      probe_in = probe_prev;
      if (take) begin
         probe_in.found     = 1'b1;
         probe_in.pick      = cell_index;
         probe_in.pick_size = size_ff;
      end
      if (frees) begin
         probe_in.freed = probe_prev.freed + fpa_pkg::CNT_W'(1);
      end

      busy_in = busy_ff;
      if (grant.valid && (grant.index == cell_index)) begin
         busy_in = 1'b1;
      end else if (frees) begin
         busy_in = 1'b0;
      end
   end

   // Hold busy state
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff        <= 1'b0;
         probe_valid_ff <= 1'b0;
      end else begin
         busy_ff        <= busy_in;
         probe_valid_ff <= probe_prev.valid;
      end
   end

   // Write size, owner and advance the token
   always_ff @(posedge clock) begin
      if (load.valid && (32'(load.index) == 32'(cell_index))) begin
         size_ff <= load.size;
      end
      if (grant.valid && (grant.index == cell_index)) begin
         owner_ff <= grant.owner;
      end
      probe_ff <= probe_in;
   end

   always_comb begin
      probe_next       = probe_ff;
      probe_next.valid = probe_valid_ff;
   end

endmodule

### hw/rtl/fpa_ctrl.sv
// Sequencer: accepts items, launches the search token, commits grants and holds the result.
`timescale 1ns / 1ps

module fpa_ctrl (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  fpa_pkg::req_type              req_payload,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output fpa_pkg::rsp_type              rsp_payload,
   input  logic                          csr_write_enable,
   input  logic [fpa_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [fpa_pkg::CSR_DATA_W-1:0] csr_write_data,
   output fpa_pkg::cfg_type              cfg,
   output fpa_pkg::load_type             load,
   output fpa_pkg::grant_type            grant,
   output fpa_pkg::probe_type            probe_launch,
   input  fpa_pkg::probe_type            probe_done
);

   fpa_pkg::state_type state_ff;
   fpa_pkg::state_type state_in;

   logic [fpa_pkg::POLICY_W-1:0] policy_ff;
   logic [fpa_pkg::LIMIT_W-1:0]  limit_ff;

   fpa_pkg::rsp_type   result_ff;
   fpa_pkg::rsp_type   result_in;
   logic               commit_ff;
   logic               commit_in;
   logic [fpa_pkg::IDX_W-1:0] commit_idx_ff;
   logic [fpa_pkg::IDX_W-1:0] commit_idx_in;
   logic [fpa_pkg::PID_W-1:0] commit_pid_ff;
   logic [fpa_pkg::PID_W-1:0] commit_pid_in;

   fpa_pkg::rsp_type rsp_ff;
   logic             rsp_valid_ff;
   logic             rsp_free;
   logic             rsp_load;
   logic             req_accept;
   logic             is_search;

   assign rsp_free   = !rsp_valid_ff || !rsp_stall;
   assign req_accept = req_valid && !req_stall;
   assign is_search  = (req_payload.mode == fpa_pkg::MODE_ALLOC)
                       || (req_payload.mode == fpa_pkg::MODE_RELEASE);

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         fpa_pkg::FPA_IDLE: begin
            if (req_valid) begin
               state_in = is_search ? fpa_pkg::FPA_SCAN : fpa_pkg::FPA_FINISH;
            end
         end
         fpa_pkg::FPA_SCAN: begin
            if (probe_done.valid) begin
               state_in = fpa_pkg::FPA_FINISH;
            end
         end
         fpa_pkg::FPA_FINISH: begin
            if (rsp_free) begin
               state_in = fpa_pkg::FPA_IDLE;
            end
         end
         default: state_in = fpa_pkg::FPA_IDLE;
      endcase
   end

   // Outputs and result capture
   always_comb begin
      req_stall     = 1'b1;
      rsp_load      = 1'b0;
      result_in     = result_ff;
      commit_in     = commit_ff;
      commit_idx_in = commit_idx_ff;
      commit_pid_in = commit_pid_ff;

      probe_launch            = '0;
      probe_launch.is_release = (req_payload.mode == fpa_pkg::MODE_RELEASE);
      probe_launch.amount     = req_payload.amount;
      probe_launch.pid        = req_payload.process_id;

      load.index = req_payload.partition_index;
      load.size  = req_payload.amount;
      load.valid = 1'b0;

      grant.valid = 1'b0;
      grant.index = commit_idx_ff;
      grant.owner = commit_pid_ff;

      case (state_ff)
         fpa_pkg::FPA_IDLE: begin
            req_stall          = 1'b0;
            probe_launch.valid = req_valid && is_search;
            load.valid         = req_valid && (req_payload.mode == fpa_pkg::MODE_LOAD);
            commit_in          = 1'b0;
            result_in          = '0;
            result_in.status   = (req_payload.mode == fpa_pkg::MODE_LOAD)
                                 ? fpa_pkg::STATUS_LOADED : fpa_pkg::STATUS_NONE;
            commit_pid_in      = req_payload.process_id;
         end
         fpa_pkg::FPA_SCAN: begin
            if (probe_done.valid) begin
               result_in = '0;
               if (probe_done.is_release) begin
                  result_in.status      = (probe_done.freed != '0)
                                          ? fpa_pkg::STATUS_RELEASED : fpa_pkg::STATUS_NONE;
                  result_in.freed_count = fpa_pkg::FREED_W'(probe_done.freed);
               end else if (probe_done.found) begin
                  result_in.status            = fpa_pkg::STATUS_GRANTED;
                  result_in.granted_partition = fpa_pkg::idx_low4(probe_done.pick);
                  commit_in                   = 1'b1;
                  commit_idx_in               = probe_done.pick;
               end else begin
                  result_in.status = fpa_pkg::STATUS_NOFIT;
               end
            end
         end
         fpa_pkg::FPA_FINISH: begin
            rsp_load    = rsp_free;
            grant.valid = rsp_free && commit_ff;
         end
         default: begin
            req_stall = 1'b1;
         end
      endcase
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= fpa_pkg::FPA_IDLE;
         rsp_valid_ff <= 1'b0;
         commit_ff    <= 1'b0;
         policy_ff    <= fpa_pkg::POLICY_FIRST;
         limit_ff     <= fpa_pkg::LIMIT_RESET;
      end else begin
         state_ff  <= state_in;
         commit_ff <= commit_in;
         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
         if (csr_write_enable) begin
            case (csr_index)
               fpa_pkg::CSR_FIT_POLICY: policy_ff <= csr_write_data[fpa_pkg::POLICY_W-1:0];
               fpa_pkg::CSR_PARTS_USED: limit_ff  <= csr_write_data[fpa_pkg::LIMIT_W-1:0];
               default: policy_ff <= policy_ff;
            endcase
         end
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      result_ff     <= result_in;
      commit_idx_ff <= commit_idx_in;
      commit_pid_ff <= commit_pid_in;
      if (rsp_load) begin
         rsp_ff <= result_ff;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;
   assign cfg.policy  = policy_ff;
   assign cfg.limit   = limit_ff;

`ifndef ASSERT_OFF
   a_done_in_scan: assert property (@(posedge clock) disable iff (reset)
      probe_done.valid |-> state_ff == fpa_pkg::FPA_SCAN)
      else $error("search token left the chain outside a scan");

   a_accept_leaves_idle: assert property (@(posedge clock) disable iff (reset)
      req_accept |=> state_ff != fpa_pkg::FPA_IDLE)
      else $error("accepted item did not start work");

   a_grant_with_result: assert property (@(posedge clock) disable iff (reset)
      grant.valid |-> rsp_load && result_ff.status == fpa_pkg::STATUS_GRANTED)
      else $error("grant committed without a granted result");

   a_rsp_from_finish: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff) == fpa_pkg::FPA_FINISH)
      else $error("result appeared outside the finish step");
`endif

endmodule

### hw/rtl/fixed_partition_allocator_unit.sv
// Top level of the fixed-partition allocator: sequencer plus a chain of partition cells.
`timescale 1ns / 1ps

// Fixed-partition allocator. Load items write partition sizes, allocate items grant a free
// partition large enough for the request (first, best or worst fit, ties to the lowest
// index), release items free every partition the given process owns; both searches cover
// only the partitions below the limit register. Each item returns one result. Load items
// and unknown modes go straight from acceptance to the finish step; allocate and release
// items first pass the search token along the chain of partition cells one cell per cycle,
// then decide the result, then commit the grant and present the result. One item is worked
// on at a time; the next item is accepted while a finished result still waits to be taken.
// Write configuration only while no item is in flight; a write is applied at once.

module fixed_partition_allocator_unit (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_stall,
   input  fpa_pkg::req_type               req_payload,
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output fpa_pkg::rsp_type               rsp_payload,
   input  logic                           csr_write_enable,
   input  logic [fpa_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [fpa_pkg::CSR_DATA_W-1:0] csr_write_data
);

   fpa_pkg::cfg_type   cfg;
   fpa_pkg::load_type  load;
   fpa_pkg::grant_type grant;
   fpa_pkg::probe_type chain [fpa_pkg::NUM_PARTS+1];

   // Sequence items
   fpa_ctrl u_ctrl (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_payload      (req_payload),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_payload      (rsp_payload),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .cfg              (cfg),
      .load             (load),
      .grant            (grant),
      .probe_launch     (chain[0]),
      .probe_done       (chain[fpa_pkg::NUM_PARTS])
   );

   // Build the cell chain
   for (genvar g = 0; g < fpa_pkg::NUM_PARTS; g++) begin : g_cell
      fpa_cell u_cell (
         .clock      (clock),
         .reset      (reset),
         .cell_index (fpa_pkg::IDX_W'(g)),
         .cfg        (cfg),
         .load       (load),
         .grant      (grant),
         .probe_prev (chain[g]),
         .probe_next (chain[g+1])
      );
   end

endmodule

### tb/testbench.sv
// Self-checking testbench for the fixed-partition allocator unit.
`timescale 1ns / 1ps

module testbench;

   // Codes the package leaves unnamed
   localparam logic [fpa_pkg::MODE_W-1:0]   MODE_UNUSED  = 2'd3;
   localparam logic [fpa_pkg::POLICY_W-1:0] POLICY_SPARE = 2'd3;

   // Policy codes as written to the register port
   localparam logic [fpa_pkg::CSR_DATA_W-1:0] PLAN_FIRST =
      fpa_pkg::CSR_DATA_W'(fpa_pkg::POLICY_FIRST);
   localparam logic [fpa_pkg::CSR_DATA_W-1:0] PLAN_BEST =
      fpa_pkg::CSR_DATA_W'(fpa_pkg::POLICY_BEST);
   localparam logic [fpa_pkg::CSR_DATA_W-1:0] PLAN_WORST =
      fpa_pkg::CSR_DATA_W'(fpa_pkg::POLICY_WORST);
   localparam logic [fpa_pkg::CSR_DATA_W-1:0] PLAN_SPARE =
      fpa_pkg::CSR_DATA_W'(POLICY_SPARE);

   localparam int PHASES          = 13;
   localparam int ITEMS_PER_PHASE = 130;
   localparam int SETTLE_CYCLES   = 24;

   logic                           clock = 1'b0;
   logic                           reset = 1'b1;
   logic                           req_valid = 1'b0;
   logic                           req_stall;
   fpa_pkg::req_type               req_payload = '0;
   logic                           rsp_valid;
   logic                           rsp_stall = 1'b0;
   fpa_pkg::rsp_type               rsp_payload;
   logic                           csr_write_enable = 1'b0;
   logic [fpa_pkg::CSR_IDX_W-1:0]  csr_index = fpa_pkg::CSR_FIT_POLICY;
   logic [fpa_pkg::CSR_DATA_W-1:0] csr_write_data = '0;

   fixed_partition_allocator_unit uut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_payload      (req_payload),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_payload      (rsp_payload),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data)
   );

   always #5 clock = ~clock;

   // Shadow copy of the partition table and settings
   logic [fpa_pkg::AMOUNT_W-1:0] size_tab  [fpa_pkg::NUM_PARTS];
   logic                         busy_tab  [fpa_pkg::NUM_PARTS];
   logic [fpa_pkg::PID_W-1:0]    owner_tab [fpa_pkg::NUM_PARTS];
   logic [fpa_pkg::POLICY_W-1:0] fit_mode     = fpa_pkg::POLICY_FIRST;
   logic [fpa_pkg::LIMIT_W-1:0]  search_limit = fpa_pkg::LIMIT_RESET;

   fpa_pkg::rsp_type outcome_queue [$];

   typedef struct {
      fpa_pkg::req_type item;
      bit               typed;
      fpa_pkg::rsp_type want;
   } directed_row_type;

   directed_row_type directed_rows [$];

   logic [fpa_pkg::PID_W-1:0] pid_pool [8] =
      '{8'h00, 8'hFF, 8'h01, 8'h80, 8'h5A, 8'hA5, 8'h7F, 8'h13};

   logic [fpa_pkg::CSR_DATA_W-1:0] policy_plan [PHASES] =
      '{PLAN_BEST, PLAN_WORST, PLAN_SPARE, PLAN_FIRST, PLAN_BEST, PLAN_WORST, PLAN_FIRST,
        PLAN_BEST, PLAN_WORST, PLAN_SPARE, PLAN_BEST, PLAN_WORST, PLAN_FIRST};
   logic [fpa_pkg::CSR_DATA_W-1:0] limit_plan [PHASES] =
      '{5'd16, 5'd16, 5'd16, 5'd8, 5'd1, 5'd0, 5'd31, 5'd17, 5'd5, 5'd2, 5'd12, 5'd31, 5'd16};

   int fail_count = 0;
   int burst_left = 0;
   int n_load = 0, n_alloc = 0, n_grant = 0, n_release = 0, n_freed = 0, n_other = 0;
   int settings_run = 0;

   initial begin
      for (int k = 0; k < fpa_pkg::NUM_PARTS; k++) begin
         size_tab[k]  = '0;
         busy_tab[k]  = 1'b0;
         owner_tab[k] = '0;
      end
   end

   // Compute the result of one item and update the shadow table
   function automatic fpa_pkg::rsp_type allocator_outcome(fpa_pkg::req_type r);
      fpa_pkg::rsp_type o;
      int               n;
      int               pick;
      int               freed;
      bit               found;
      bit               first_like;
      o          = '0;
      o.status   = fpa_pkg::STATUS_NONE;
      n          = (search_limit > fpa_pkg::NUM_PARTS) ? fpa_pkg::NUM_PARTS
                                                       : int'(search_limit);
      pick       = 0;
      freed      = 0;
      found      = 1'b0;
      first_like = (fit_mode != fpa_pkg::POLICY_BEST) && (fit_mode != fpa_pkg::POLICY_WORST);
      case (r.mode)
         fpa_pkg::MODE_LOAD: begin
            size_tab[r.partition_index] = r.amount;
            o.status = fpa_pkg::STATUS_LOADED;
         end
         fpa_pkg::MODE_ALLOC: begin
            for (int k = 0; k < n; k++) begin
               if (!busy_tab[k] && size_tab[k] >= r.amount && !(found && first_like)) begin
                  if (!found) begin
                     found = 1'b1;
                     pick  = k;
                  end else if (fit_mode == fpa_pkg::POLICY_BEST
                               && size_tab[k] < size_tab[pick]) begin
                     pick = k;
                  end else if (fit_mode == fpa_pkg::POLICY_WORST
                               && size_tab[k] > size_tab[pick]) begin
                     pick = k;
                  end
               end
            end
            if (found) begin
               busy_tab[pick]      = 1'b1;
               owner_tab[pick]     = r.process_id;
               o.status            = fpa_pkg::STATUS_GRANTED;
               o.granted_partition = fpa_pkg::GRANT_W'(pick);
            end else begin
               o.status = fpa_pkg::STATUS_NOFIT;
            end
         end
         fpa_pkg::MODE_RELEASE: begin
            for (int k = 0; k < n; k++) begin
               if (busy_tab[k] && owner_tab[k] == r.process_id) begin
                  busy_tab[k] = 1'b0;
                  freed++;
               end
            end
            o.freed_count = fpa_pkg::FREED_W'(freed);
            o.status      = (freed != 0) ? fpa_pkg::STATUS_RELEASED : fpa_pkg::STATUS_NONE;
         end
         default: ;
      endcase
      return o;
   endfunction

   // Build a random item, biased toward sizes present in the table
   function automatic fpa_pkg::req_type random_item();
      fpa_pkg::req_type             r;
      int                           roll;
      logic [fpa_pkg::AMOUNT_W-1:0] base;
      r.partition_index = fpa_pkg::PIDX_W'($urandom_range(0, 15));
      r.amount          = fpa_pkg::AMOUNT_W'($urandom());
      r.process_id      = fpa_pkg::PID_W'($urandom());
      roll              = $urandom_range(0, 99);
      if ($urandom_range(0, 4) != 0)
         r.process_id = pid_pool[$urandom_range(0, 7)];
      if (roll < 12) begin
         r.mode = fpa_pkg::MODE_LOAD;
         if ($urandom_range(0, 1) != 0)
            r.amount = fpa_pkg::AMOUNT_W'($urandom_range(0, 16'h1000));
      end else if (roll < 62) begin
         r.mode = fpa_pkg::MODE_ALLOC;
         base   = size_tab[$urandom_range(0, fpa_pkg::NUM_PARTS - 1)];
         roll   = $urandom_range(0, 99);
         if (roll < 40)
            r.amount = base;
         else if (roll < 60)
            r.amount = (base == '1) ? base : base + 1'b1;
         else if (roll < 85)
            r.amount = fpa_pkg::AMOUNT_W'($urandom_range(0, 16'h0FFF));
      end else if (roll < 92) begin
         r.mode = fpa_pkg::MODE_RELEASE;
      end else begin
         r.mode = MODE_UNUSED;
      end
      return r;
   endfunction

   task automatic add_row(input logic [fpa_pkg::MODE_W-1:0] m,
                          input logic [fpa_pkg::PIDX_W-1:0] idx,
                          input logic [fpa_pkg::AMOUNT_W-1:0] amt,
                          input logic [fpa_pkg::PID_W-1:0] pid,
                          input bit typed, input logic [fpa_pkg::STATUS_W-1:0] st,
                          input logic [fpa_pkg::GRANT_W-1:0] gr,
                          input logic [fpa_pkg::FREED_W-1:0] fr);
      directed_row_type row;
      row.item.mode                 = m;
      row.item.partition_index      = idx;
      row.item.amount               = amt;
      row.item.process_id           = pid;
      row.typed                     = typed;
      row.want.status               = st;
      row.want.granted_partition    = gr;
      row.want.freed_count          = fr;
      directed_rows.push_back(row);
   endtask

   // Offer one item, hold it until taken, then record what should come back
   task automatic send_item(input fpa_pkg::req_type r, input bit typed,
                            input fpa_pkg::rsp_type want);
      fpa_pkg::rsp_type predicted;
      req_valid   <= 1'b1;
      req_payload <= r;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      predicted = allocator_outcome(r);
      outcome_queue.push_back(typed ? want : predicted);
      case (r.mode)
         fpa_pkg::MODE_LOAD:    n_load++;
         fpa_pkg::MODE_ALLOC: begin
            n_alloc++;
            if (predicted.status == fpa_pkg::STATUS_GRANTED) n_grant++;
         end
         fpa_pkg::MODE_RELEASE: begin
            n_release++;
            n_freed += predicted.freed_count;
         end
         default:      n_other++;
      endcase
      // End the burst with a gap of random length
      if (burst_left > 0) begin
         burst_left--;
      end else begin
         req_valid <= 1'b0;
         if ($urandom_range(0, 4) == 0)
            repeat ($urandom_range(10, 30)) @(posedge clock);
         else
            repeat ($urandom_range(1, 4)) @(posedge clock);
         case ($urandom_range(0, 9))
            0:       burst_left = $urandom_range(30, 60);
            1, 2:    burst_left = $urandom_range(5, 20);
            default: burst_left = $urandom_range(0, 4);
         endcase
      end
   endtask

   // Drop valid and wait until every result is back and the block is idle
   task automatic drain();
      req_valid <= 1'b0;
      while (outcome_queue.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_settings(input logic [fpa_pkg::CSR_DATA_W-1:0] pol,
                                 input logic [fpa_pkg::CSR_DATA_W-1:0] lim);
      csr_write_enable <= 1'b1;
      csr_index        <= fpa_pkg::CSR_FIT_POLICY;
      csr_write_data   <= pol;
      @(posedge clock);
      fit_mode       = pol[fpa_pkg::POLICY_W-1:0];
      csr_index      <= fpa_pkg::CSR_PARTS_USED;
      csr_write_data <= lim;
      @(posedge clock);
      search_limit     = lim[fpa_pkg::LIMIT_W-1:0];
      csr_write_enable <= 1'b0;
      @(posedge clock);
      settings_run++;
   endtask

   // Compare each result with the oldest expectation
   always @(posedge clock) begin : check_results
      fpa_pkg::rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (outcome_queue.size() == 0) begin
            $error("result arrived with no item outstanding: %h", rsp_payload);
            fail_count++;
         end else begin
            want = outcome_queue.pop_front();
            if (rsp_payload.status !== want.status) begin
               $error("status: expected %0d, got %0d", want.status, rsp_payload.status);
               fail_count++;
            end
            if (rsp_payload.granted_partition !== want.granted_partition) begin
               $error("granted_partition: expected %0d, got %0d",
                      want.granted_partition, rsp_payload.granted_partition);
               fail_count++;
            end
            if (rsp_payload.freed_count !== want.freed_count) begin
               $error("freed_count: expected %0d, got %0d",
                      want.freed_count, rsp_payload.freed_count);
               fail_count++;
            end
         end
      end
   end

   // Receiver stalls in segments of varying density, with one long hold-off
   initial begin : receiver
      int cycle_no;
      int seg_kind;
      int seg_left;
      int hold_left;
      bit held;
      cycle_no  = 0;
      seg_kind  = 0;
      seg_left  = 0;
      hold_left = 0;
      held      = 1'b0;
      forever begin
         @(posedge clock);
         cycle_no++;
         if (!held && cycle_no >= 6000 && req_valid) begin
            held      = 1'b1;
            hold_left = 400;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_stall <= 1'b1;
         end else begin
            if (seg_left == 0) begin
               seg_kind = $urandom_range(0, 3);
               seg_left = $urandom_range(8, 80);
            end
            seg_left--;
            case (seg_kind)
               0:       rsp_stall <= 1'b0;
               1:       rsp_stall <= ($urandom_range(0, 3) == 0);
               2:       rsp_stall <= ($urandom_range(0, 3) != 0);
               default: rsp_stall <= ((cycle_no % 5) < 2);
            endcase
         end
      end
   end

   // Main stimulus: directed table, then random phases under changing settings
   initial begin : stimulus
      fpa_pkg::rsp_type blank;
      blank = '0;

      // After reset: nothing owned, unknown mode answers nothing released
      add_row(fpa_pkg::MODE_RELEASE, 4'd0, 16'h0000, 8'h00, 1, fpa_pkg::STATUS_NONE,
              4'd0, 5'd0);
      add_row(MODE_UNUSED, 4'hF, 16'hFFFF, 8'hFF, 1, fpa_pkg::STATUS_NONE, 4'd0, 5'd0);
      // Load every partition before any search
      add_row(fpa_pkg::MODE_LOAD, 4'd0,  16'h0200, 8'h00, 1, fpa_pkg::STATUS_LOADED, 4'd0, 5'd0);
      add_row(fpa_pkg::MODE_LOAD, 4'd1,  16'hFFFF, 8'hFF, 1, fpa_pkg::STATUS_LOADED, 4'd0, 5'd0);
      add_row(fpa_pkg::MODE_LOAD, 4'd2,  16'h0000, 8'h00, 1, fpa_pkg::STATUS_LOADED, 4'd0, 5'd0);
      add_row(fpa_pkg::MODE_LOAD, 4'd3,  16'h8000, 8'h00, 1, fpa_pkg::STATUS_LOADED, 4'd0, 5'd0);
      add_row(fpa_pkg::MODE_LOAD, 4'd4,  16'h0400, 8'h00, 1, fpa_pkg::STATUS_LOADED, 4'd0, 5'd0);
      add_row(fpa_pkg::MODE_LOAD, 4'd5,  16'h0300, 8'h00, 1, fpa_pkg::STATUS_LOADED, 4'd0, 5'd0);
      add_row(fpa_pkg::MODE_LOAD, 4'd6,  16'h1234, 8'h00, 1, fpa_pkg::STATUS_LOADED, 4'd0, 5'd0);
      add_row(fpa_pkg::MODE_LOAD, 4'd7,  16'h0001, 8'h00, 1, fpa_pkg::STATUS_LOADED, 4'd0, 5'd0);
      add_row(fpa_pkg::MODE_LOAD, 4'd8,  16'h7FFF, 8'h00, 1, fpa_pkg::STATUS_LOADED, 4'd0, 5'd0);
      add_row(fpa_pkg::MODE_LOAD, 4'd9,  16'h0300, 8'h00, 1, fpa_pkg::STATUS_LOADED, 4'd0, 5'd0);
      add_row(fpa_pkg::MODE_LOAD, 4'd10, 16'hFFFE, 8'h00, 1, fpa_pkg::STATUS_LOADED, 4'd0, 5'd0);
      add_row(fpa_pkg::MODE_LOAD, 4'd11, 16'h00FF, 8'h00, 1, fpa_pkg::STATUS_LOADED, 4'd0, 5'd0);
      add_row(fpa_pkg::MODE_LOAD, 4'd12, 16'h5555, 8'h00, 1, fpa_pkg::STATUS_LOADED, 4'd0, 5'd0);
      add_row(fpa_pkg::MODE_LOAD, 4'd13, 16'hAAAA, 8'h00, 1, fpa_pkg::STATUS_LOADED, 4'd0, 5'd0);
      add_row(fpa_pkg::MODE_LOAD, 4'd14, 16'h0800, 8'h00, 1, fpa_pkg::STATUS_LOADED, 4'd0, 5'd0);
      add_row(fpa_pkg::MODE_LOAD, 4'd15, 16'h0302, 8'h00, 1, fpa_pkg::STATUS_LOADED, 4'd0, 5'd0);
      // Zero request fits the first free partition; full size fits only one
      add_row(fpa_pkg::MODE_ALLOC, 4'd0, 16'h0000, 8'hFF, 1, fpa_pkg::STATUS_GRANTED,
              4'd0, 5'd0);
      add_row(fpa_pkg::MODE_ALLOC, 4'd0, 16'hFFFF, 8'hAA, 1, fpa_pkg::STATUS_GRANTED,
              4'd1, 5'd0);
      add_row(fpa_pkg::MODE_ALLOC, 4'd0, 16'hFFFF, 8'h55, 1, fpa_pkg::STATUS_NOFIT,
              4'd0, 5'd0);
      add_row(fpa_pkg::MODE_ALLOC, 4'd0, 16'h0300, 8'h12, 0, fpa_pkg::STATUS_NONE,
              4'd0, 5'd0);
      // Reload a busy partition, release its owner twice, then release the owner of partition 0
      add_row(fpa_pkg::MODE_LOAD, 4'd1, 16'h0010, 8'h00, 1, fpa_pkg::STATUS_LOADED,
              4'd0, 5'd0);
      add_row(fpa_pkg::MODE_RELEASE, 4'd0, 16'h0000, 8'hAA, 1, fpa_pkg::STATUS_RELEASED,
              4'd0, 5'd1);
      add_row(fpa_pkg::MODE_RELEASE, 4'd0, 16'h0000, 8'hAA, 1, fpa_pkg::STATUS_NONE,
              4'd0, 5'd0);
      add_row(fpa_pkg::MODE_RELEASE, 4'd0, 16'h0000, 8'hFF, 1, fpa_pkg::STATUS_RELEASED,
              4'd0, 5'd1);

      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (directed_rows[i])
         send_item(directed_rows[i].item, directed_rows[i].typed, directed_rows[i].want);
      drain();

      for (int p = 0; p < PHASES; p++) begin
         write_settings(policy_plan[p], limit_plan[p]);
         repeat (ITEMS_PER_PHASE) send_item(random_item(), 1'b0, blank);
         drain();
      end

      $display("Covered %0d items: %0d loads, %0d allocations (%0d granted), %0d releases",
               n_load + n_alloc + n_release + n_other, n_load, n_alloc, n_grant, n_release);
      $display("freeing %0d partitions, %0d unknown-mode items, %0d register settings",
               n_freed, n_other, settings_run);
      if (fail_count == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

   // Stop a hung run
   initial begin : watchdog
      #5_000_000;
      $display("TB_ERROR");
      $finish;
   end

endmodule
